[design/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define OLST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define OLST_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/olst_pkg.sv]
// types, codes and sizes shared by the ordered list store
// no dependencies
package olst_pkg;

  localparam int unsigned LIST_DEPTH  = 16;
  localparam int unsigned IDX_W       = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_APPEND = 3'd1;
  localparam logic [2:0] KIND_INSERT = 3'd2;
  localparam logic [2:0] KIND_DELETE = 3'd3;
  localparam logic [2:0] KIND_SEARCH = 3'd4;
  localparam logic [2:0] KIND_READ   = 3'd5;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BADPOS   = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         found_index;
    logic signed [31:0] read_value;
    logic [4:0]         element_count;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_INSERT,
    OP_DELETE,
    OP_SEARCH,
    OP_READ,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [3:0]         position;
    logic signed [31:0] value;
  } cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

[design/olst_front.sv]
// front end: accepts items, decodes the kind and queues commands
// depends on olst_pkg
module olst_front import olst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output q_head_t  head_o,
  input  logic     pop_i
);

  cmd_t               queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QFILL_W-1:0] fill_q, fill_d;
  cmd_t               cmd_dec;
  logic               push;

  always_comb begin
    cmd_dec.position = in_item_i.position;
    cmd_dec.value    = in_item_i.value;
    unique case (in_item_i.kind)
      KIND_CLEAR:  cmd_dec.op = OP_CLEAR;
      KIND_APPEND: cmd_dec.op = OP_APPEND;
      KIND_INSERT: cmd_dec.op = OP_INSERT;
      KIND_DELETE: cmd_dec.op = OP_DELETE;
      KIND_SEARCH: cmd_dec.op = OP_SEARCH;
      KIND_READ:   cmd_dec.op = OP_READ;
      default:     cmd_dec.op = OP_NONE;
    endcase
  end

  assign in_ready_o = (fill_q != QFILL_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (!push && pop_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_dec;
    end
  end

  assign head_o.valid = (fill_q != '0);
  assign head_o.cmd   = queue_q[rd_ptr_q];

endmodule

[design/olst_back.sv]
// back end: list cells, count, search scan and result register
// depends on olst_pkg
module olst_back import olst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_head_t   head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [0:0] {S_IDLE, S_SCAN} state_e;
  typedef enum logic [1:0] {W_NONE, W_APPEND, W_INSERT, W_DELETE} wr_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic signed [31:0] key_q, key_d;
  logic               out_valid_q;
  out_item_t          out_q, res;
  logic               load_out, out_free;
  logic signed [31:0] entries_q [LIST_DEPTH];
  logic signed [31:0] entry_prev [LIST_DEPTH];
  logic signed [31:0] entry_next [LIST_DEPTH];
  logic [IDX_W-1:0]   rd_idx, pos_idx, app_idx;
  logic signed [31:0] rd_data;
  logic               pos_ok, full;
  wr_e                wr_op;

  assign out_free = !out_valid_q || out_ready_i;
  assign pos_idx  = IDX_W'(head_i.cmd.position);
  assign app_idx  = IDX_W'(count_q);
  assign pos_ok   = CNT_W'(head_i.cmd.position) < count_q;
  assign full     = (count_q == CNT_W'(LIST_DEPTH));

  // single read port, shared by the scan and by read
  assign rd_idx  = (state_q == S_SCAN) ? IDX_W'(scan_q) : pos_idx;
  assign rd_data = entries_q[rd_idx];

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    res      = '0;
    count_d  = count_q;
    state_d  = state_q;
    scan_d   = scan_q;
    key_d    = key_q;
    wr_op    = W_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid && out_free) begin
          pop_o    = 1'b1;
          load_out = 1'b1;
          unique case (head_i.cmd.op)
            OP_CLEAR: count_d = '0;
            OP_APPEND: begin
              if (full) begin
                res.status = STATUS_FULL;
              end else begin
                wr_op   = W_APPEND;
                count_d = count_q + 1'b1;
              end
            end
            OP_INSERT: begin
              if (!pos_ok) begin
                res.status = STATUS_BADPOS;
              end else if (full) begin
                res.status = STATUS_FULL;
              end else begin
                wr_op   = W_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            OP_DELETE: begin
              if (!pos_ok) begin
                res.status = STATUS_BADPOS;
              end else begin
                wr_op   = W_DELETE;
                count_d = count_q - 1'b1;
              end
            end
            OP_SEARCH: begin
              load_out = 1'b0;
              state_d  = S_SCAN;
              scan_d   = '0;
              key_d    = head_i.cmd.value;
            end
            OP_READ: begin
              if (!pos_ok) begin
                res.status = STATUS_BADPOS;
              end else begin
                res.read_value = rd_data;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // one entry a cycle, first match wins
        if (scan_q >= count_q) begin
          if (out_free) begin
            load_out   = 1'b1;
            res.status = STATUS_NOTFOUND;
            state_d    = S_IDLE;
          end
        end else if (rd_data == key_q) begin
          if (out_free) begin
            load_out        = 1'b1;
            res.found_index = 4'(scan_q);
            state_d         = S_IDLE;
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
    res.element_count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (load_out) begin
      out_q <= res;
    end
  end

  // neighbour taps for the shift chain
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    if (g > 0) begin : g_prev
      assign entry_prev[g] = entries_q[g-1];
    end else begin : g_first
      assign entry_prev[g] = '0;
    end
    if (g < LIST_DEPTH - 1) begin : g_next
      assign entry_next[g] = entries_q[g+1];
    end else begin : g_last
      assign entry_next[g] = '0;
    end

    always_ff @(posedge clk_i) begin
      case (wr_op)
        W_APPEND: begin
          if (app_idx == IDX_W'(g)) begin
            entries_q[g] <= head_i.cmd.value;
          end
        end
        W_INSERT: begin
          if (IDX_W'(g) > pos_idx) begin
            entries_q[g] <= entry_prev[g];
          end else if (IDX_W'(g) == pos_idx) begin
            entries_q[g] <= head_i.cmd.value;
          end
        end
        W_DELETE: begin
          if (IDX_W'(g) >= pos_idx) begin
            entries_q[g] <= entry_next[g];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[design/ordered_list_store_core.sv]
// an input beat is registered in the command queue and its result in the output register;
// a search then scans the entries in order, up to the first match or the end of the list
// throughput: one item a cycle unless the output stalls; search is bound by its scan
// a two-entry command queue lets input beats land while the back end or output stalls
// reset (async, active low) empties the list and the queue; entry contents are not cleared
module ordered_list_store_core import olst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  q_head_t head;
  logic    pop;

  olst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  olst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[design/olst_checker.sv]
// port-level checks on the ordered list store, bound to the top level
// depends on olst_pkg and assert_macros.svh
`include "assert_macros.svh"

module olst_checker import olst_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  `OLST_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !out_valid_o, "result during reset")
  `OLST_ASSERT(a_count_bound, out_valid_o |-> out_item_o.element_count <= 5'(LIST_DEPTH), "count above depth")
  `OLST_ASSERT(a_index_only_on_hit, out_valid_o && out_item_o.found_index != '0 |-> out_item_o.status == STATUS_OK, "index on failed op")
  `OLST_ASSERT(a_value_only_on_read, out_valid_o && out_item_o.read_value != '0 |-> out_item_o.status == STATUS_OK, "read value on failed op")
  `OLST_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o), "stalled result changed")

endmodule

bind ordered_list_store_core olst_checker u_olst_checker (.*);
